>>> design/smed_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared constants and the control bundle that the top level sends to the
// sorting cells.
// ----------------------------------------------------------------------------
package smed_pkg;

	localparam int MAX_WINDOW_DEF   = 64;
	localparam int SAMPLE_WIDTH_DEF = 32;

	localparam int CFG_WIDTH   = 7;
	localparam int WSIZE_RESET = 3;

	localparam int IN_DATA_W   = 32;
	localparam int OUT_FIELD_W = 33;
	localparam int OUT_DATA_W  = 40;

	typedef struct packed {
		logic upd;
		logic rmv;
	} cell_ctl_t;

endpackage

>>> design/smed_cell.sv
// ----------------------------------------------------------------------------
// Sorting cell
// One slot of the sorted window. Each cell holds a sample and its age and,
// on every accepted transfer, takes its new contents from itself, a neighbor
// or the incoming sample, so that the row stays in ascending order.
// ----------------------------------------------------------------------------
module smed_cell #(
	parameter int IDX          = 0,
	parameter int SAMPLE_WIDTH = 32,
	parameter int AW           = 6,
	parameter int CW           = 7
) (
	input  logic                    clk,
	input  smed_pkg::cell_ctl_t     ctl,
	input  logic [SAMPLE_WIDTH-1:0] x,
	input  logic [CW-1:0]           cnt_c,
	input  logic [AW-1:0]           age_lim,
	input  logic                    rmab_prev,
	input  logic                    rmab_self,
	input  logic [SAMPLE_WIDTH-1:0] prev_val,
	input  logic [AW-1:0]           prev_age,
	input  logic                    prev_gt,
	input  logic [SAMPLE_WIDTH-1:0] next_val,
	input  logic [AW-1:0]           next_age,
	input  logic                    next_gt,
	output logic [SAMPLE_WIDTH-1:0] val,
	output logic [AW-1:0]           age,
	output logic                    gt,
	output logic                    rm
);
	import smed_pkg::*;

	logic [SAMPLE_WIDTH-1:0] val_q;
	logic [AW-1:0]           age_q;
	logic [SAMPLE_WIDTH-1:0] c_self_val, c_prev_val;
	logic [AW-1:0]           c_self_age, c_prev_age;
	logic                    g_self, g_prev;
	logic [SAMPLE_WIDTH-1:0] val_nxt;
	logic [AW-1:0]           age_nxt;

	assign val = val_q;
	assign age = age_q;
	assign gt  = $signed(val_q) > $signed(x);
	assign rm  = ctl.rmv && (IDX <= int'(age_lim)) && (age_q == age_lim);

	// The list after removing the oldest entry, seen at this slot and the one below.
	always_comb begin
		c_self_val = rmab_self ? next_val : val_q;
		c_self_age = rmab_self ? next_age : age_q;
		g_self     = (IDX >= int'(cnt_c)) || (rmab_self ? next_gt : gt);
		c_prev_val = rmab_prev ? val_q : prev_val;
		c_prev_age = rmab_prev ? age_q : prev_age;
		if (IDX == 0) begin
			g_prev = 1'b0;
		end else begin
			g_prev = (IDX - 1 >= int'(cnt_c)) || (rmab_prev ? gt : prev_gt);
		end
	end

	always_comb begin
		if (g_prev) begin
			val_nxt = c_prev_val;
			age_nxt = AW'(c_prev_age + 1'b1);
		end else if (g_self) begin
			val_nxt = x;
			age_nxt = '0;
		end else begin
			val_nxt = c_self_val;
			age_nxt = AW'(c_self_age + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			val_q <= val_nxt;
			age_q <= age_nxt;
		end
	end

endmodule

>>> design/smed_median_out.sv
// ----------------------------------------------------------------------------
// Median output stage
// Picks the middle entries of the sorted row, adds them and holds the
// result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module smed_median_out #(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 32,
	parameter int AW           = 6,
	parameter int CW           = 7
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic [SAMPLE_WIDTH-1:0]         vals [MAX_WINDOW],
	input  logic [CW-1:0]                   k,
	output logic                            blocked,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [smed_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import smed_pkg::*;

	logic                          valid_s1;
	logic                          out_valid_q;
	logic [OUT_FIELD_W-1:0]        out_data_q;
	logic                          move;
	logic [AW-1:0]                 idx_a, idx_b;
	logic signed [SAMPLE_WIDTH:0]  sum;

	assign move    = valid_s1 && (!out_valid_q || m_axis_tready);
	assign blocked = valid_s1 && !move;

	always_comb begin
		idx_b = AW'(k >> 1);
		idx_a = k[0] ? idx_b : AW'(idx_b - 1'b1);
		sum   = $signed({vals[idx_a][SAMPLE_WIDTH-1], vals[idx_a]})
		      + $signed({vals[idx_b][SAMPLE_WIDTH-1], vals[idx_b]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_data_q <= OUT_FIELD_W'(sum);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - OUT_FIELD_W)'(0), out_data_q};

endmodule

>>> design/sliding_window_median.sv
// ----------------------------------------------------------------------------
// Sliding window median
// Running median over the last window_size signed samples, given as twice
// the median so that even windows stay exact.
// ----------------------------------------------------------------------------
// Samples arrive on the slave stream: tdata holds the sample, tuser the
// restart flag, which empties the window before its sample is taken.
// Results leave on the master stream as a 33-bit two's complement value.
// No result is given until the window holds window_size samples; after
// that every input transfer yields one output transfer.
// A new sample enters every cycle while tready is high. The result of a sample
// is registered first in the row of sorting cells, which update at its transfer,
// and then the middle entries are added into the output register.
// When the receiver stalls, one result waits in the output register and one
// more in the stage before it; then tready drops until the receiver resumes.
// Reset empties the window and sets the window size to three. Writing the
// window size also empties the window and must only happen while idle.
// ----------------------------------------------------------------------------
module sliding_window_median #(
	parameter int MAX_WINDOW   = smed_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = smed_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [smed_pkg::CFG_WIDTH-1:0]  cfg_wdata,     // window_size
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [smed_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // sample
	input  logic                            s_axis_tuser,  // restart
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [smed_pkg::OUT_DATA_W-1:0] m_axis_tdata   // median_twice, zero pad
);
	import smed_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);

	logic [CFG_WIDTH-1:0]    wsize_q;
	logic [CW-1:0]           fill_q;
	logic [CW-1:0]           k;
	logic [CW-1:0]           fill_eff, fill_nxt, cnt_c;
	logic                    full, s_acc, produce, blocked;
	logic [AW-1:0]           age_lim;
	cell_ctl_t               ctl;
	logic [SAMPLE_WIDTH-1:0] x;

	logic [SAMPLE_WIDTH-1:0] val_w [MAX_WINDOW];
	logic [AW-1:0]           age_w [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]   gt_w, rm_w, rmab_w;

	always_comb begin
		if (wsize_q == '0) begin
			k = CW'(1);
		end else if (int'(wsize_q) > MAX_WINDOW) begin
			k = CW'(MAX_WINDOW);
		end else begin
			k = CW'(wsize_q);
		end
	end

	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !blocked;
	assign x        = s_axis_tdata[SAMPLE_WIDTH-1:0];
	assign fill_eff = s_axis_tuser ? '0 : fill_q;
	assign full     = (fill_eff == k);
	assign cnt_c    = full ? CW'(k - 1'b1) : fill_eff;
	assign fill_nxt = full ? k : CW'(fill_eff + 1'b1);
	assign produce  = (fill_nxt == k);
	assign age_lim  = AW'(k - 1'b1);
	assign ctl.upd  = s_acc;
	assign ctl.rmv  = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q <= CFG_WIDTH'(WSIZE_RESET);
			fill_q  <= '0;
		end else if (cfg_we) begin
			wsize_q <= cfg_wdata;
			fill_q  <= '0;
		end else if (s_acc) begin
			fill_q <= fill_nxt;
		end
	end

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic [SAMPLE_WIDTH-1:0] pv, nv;
		logic [AW-1:0]           pa, na;
		logic                    pg, ng, pr;

		assign rmab_w[i] = |rm_w[i:0];

		if (i == 0) begin : g_first
			assign pv = '0;
			assign pa = '0;
			assign pg = 1'b0;
			assign pr = 1'b0;
		end else begin : g_mid
			assign pv = val_w[i-1];
			assign pa = age_w[i-1];
			assign pg = gt_w[i-1];
			assign pr = rmab_w[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_last
			assign nv = '0;
			assign na = '0;
			assign ng = 1'b1;
		end else begin : g_inner
			assign nv = val_w[i+1];
			assign na = age_w[i+1];
			assign ng = gt_w[i+1];
		end

		smed_cell #(
			.IDX          (i),
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.AW           (AW),
			.CW           (CW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.x         (x),
			.cnt_c     (cnt_c),
			.age_lim   (age_lim),
			.rmab_prev (pr),
			.rmab_self (rmab_w[i]),
			.prev_val  (pv),
			.prev_age  (pa),
			.prev_gt   (pg),
			.next_val  (nv),
			.next_age  (na),
			.next_gt   (ng),
			.val       (val_w[i]),
			.age       (age_w[i]),
			.gt        (gt_w[i]),
			.rm        (rm_w[i])
		);
	end

	smed_median_out #(
		.MAX_WINDOW   (MAX_WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.AW           (AW),
		.CW           (CW)
	) u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (s_acc && produce),
		.vals          (val_w),
		.k             (k),
		.blocked       (blocked),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

`ifndef SYNTHESIS
	a_fill_bound : assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= k)
		else $error("fill count exceeds window size");

	a_one_removal : assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(rm_w))
		else $error("more than one cell selected for removal");

	a_full_removes : assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && full) |-> $onehot(rm_w))
		else $error("full window without exactly one oldest entry");

	a_out_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output transfer changed");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window median testbench
// Streams signed samples into the block with random gaps and output stalls,
// predicts every median in a local model of the window kept in ring and
// sorted order, and compares each output transfer with the oldest
// prediction. Window sizes cover the default, the clamped extremes and a
// spread of odd and even sizes.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          MAXW        = smed_pkg::MAX_WINDOW_DEF;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                            cfg_we        = 1'b0;
	logic [smed_pkg::CFG_WIDTH-1:0]  cfg_wdata     = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [smed_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                            s_axis_tuser  = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [smed_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	sliding_window_median dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic signed [31:0]              ring_mem [0:MAXW-1];
	logic signed [31:0]              sorted_mem [0:MAXW-1];
	int unsigned                     fill_cnt   = 0;
	int unsigned                     ring_ptr   = 0;
	logic [smed_pkg::CFG_WIDTH-1:0]  window_reg = smed_pkg::WSIZE_RESET;

	logic signed [smed_pkg::OUT_FIELD_W-1:0] median_queue [$];
	logic signed [smed_pkg::OUT_FIELD_W-1:0] want_median;

	int unsigned error_count  = 0;
	int unsigned cycle_count  = 0;
	int unsigned rx_hold      = 0;
	int unsigned random_items = 0;
	bit          no_idle      = 1'b0;

	function automatic int unsigned effective_size();
		if (window_reg == 0)
			return 1;
		if (window_reg > MAXW)
			return MAXW;
		return int'(window_reg);
	endfunction

	function automatic void insert_sorted(input int unsigned count, input logic signed [31:0] s);
		int unsigned i;
		i = count;
		while (i > 0 && sorted_mem[i-1] > s) begin
			sorted_mem[i] = sorted_mem[i-1];
			i--;
		end
		sorted_mem[i] = s;
	endfunction

	function automatic bit advance_window(input logic [31:0] raw, input logic restart,
		output logic signed [smed_pkg::OUT_FIELD_W-1:0] med);
		int unsigned k, h, i, j;
		bit found;
		logic signed [31:0] s;
		logic signed [smed_pkg::OUT_FIELD_W-1:0] lo, hi;
		k = effective_size();
		s = raw;
		med = '0;
		if (restart || fill_cnt > k || ring_ptr >= k) begin
			fill_cnt = 0;
			ring_ptr = 0;
		end
		if (fill_cnt < k) begin
			insert_sorted(fill_cnt, s);
			fill_cnt++;
		end else begin
			j = k - 1;
			found = 1'b0;
			for (i = 0; i < k; i++) begin
				if (!found && sorted_mem[i] == ring_mem[ring_ptr]) begin
					j = i;
					found = 1'b1;
				end
			end
			for (i = j; i + 1 < k; i++)
				sorted_mem[i] = sorted_mem[i+1];
			insert_sorted(k - 1, s);
		end
		ring_mem[ring_ptr] = s;
		ring_ptr = (ring_ptr + 1 >= k) ? 0 : ring_ptr + 1;
		if (fill_cnt < k)
			return 1'b0;
		h = k / 2;
		if (k % 2 == 1) begin
			lo = sorted_mem[h];
			med = lo <<< 1;
		end else begin
			lo = sorted_mem[h-1];
			hi = sorted_mem[h];
			med = lo + hi;
		end
		return 1'b1;
	endfunction

	function automatic logic [31:0] draw_value(input int unsigned mode);
		int v;
		case (mode)
			0: return $urandom;
			1: begin
				v = $urandom_range(0, 8);
				return v - 4;
			end
			2: begin
				case ($urandom_range(0, 6))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					3: return 32'hffff_ffff;
					4: return 32'h0000_0001;
					5: return 32'h8000_0001;
					default: return 32'h7fff_fffe;
				endcase
			end
			default: begin
				if ($urandom_range(0, 1) == 1)
					return 32'h7fff_ff00 | $urandom_range(0, 255);
				return 32'h8000_0000 | $urandom_range(0, 255);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [39:0] got,
		input logic [39:0] want);
		$display("mismatch (%s): got %h, want %h", what, got, want);
		error_count++;
	endtask

	task automatic send_sample(input logic [31:0] value, input logic restart);
		int unsigned gap;
		logic signed [smed_pkg::OUT_FIELD_W-1:0] med;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= restart;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (advance_window(value, restart, med))
			median_queue = {median_queue, med};
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (median_queue.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_window(input logic [smed_pkg::CFG_WIDTH-1:0] size);
		cfg_we    <= 1'b1;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we     <= 1'b0;
		window_reg = size;
		fill_cnt   = 0;
		ring_ptr   = 0;
	endtask

	task automatic test_directed();
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h0000_0000, 1'b1);
		send_sample(32'hffff_ffff, 1'b0);
		send_sample(32'h0000_0001, 1'b0);
		send_sample(32'h0000_0005, 1'b0);
		send_sample(32'h0000_0005, 1'b0);
		send_sample(32'h0000_0005, 1'b0);
		send_sample(32'h0000_0005, 1'b0);
		send_sample(32'h0000_0004, 1'b1);
		send_sample(32'h0000_0004, 1'b0);
		wait_idle();
		write_window(7'd2);
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'hffff_fffe, 1'b0);
	endtask

	task automatic test_size_limits();
		logic [smed_pkg::CFG_WIDTH-1:0] sizes [5];
		int unsigned n;
		sizes = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd65};
		foreach (sizes[p]) begin
			wait_idle();
			write_window(sizes[p]);
			n = effective_size() + 12;
			repeat (n)
				send_sample(draw_value($urandom_range(0, 1)), 1'b0);
		end
	endtask

	task automatic test_random_traffic();
		int unsigned r, n, mode;
		while (random_items < 450) begin
			wait_idle();
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) != 0) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					write_window(7'($urandom_range(1, 9)));
				else if (r < 75)
					write_window(7'($urandom_range(10, 40)));
				else if (r < 85)
					write_window(7'd0);
				else if (r < 92)
					write_window(7'd64);
				else
					write_window(7'($urandom_range(65, 127)));
			end
			mode = $urandom_range(0, 3);
			n = effective_size() + $urandom_range(3, 30);
			repeat (n) begin
				send_sample(draw_value(mode), $urandom_range(0, 24) == 0);
				random_items++;
			end
		end
		no_idle = 1'b0;
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (median_queue.size() == 0) begin
				report_mismatch("result with nothing pending", m_axis_tdata, '0);
			end else begin
				want_median = median_queue.pop_front();
				if (m_axis_tdata[smed_pkg::OUT_FIELD_W-1:0] !== want_median)
					report_mismatch("median_twice", m_axis_tdata, {7'd0, want_median});
				if (m_axis_tdata[smed_pkg::OUT_DATA_W-1:smed_pkg::OUT_FIELD_W] !== '0)
					report_mismatch("padding", m_axis_tdata, {7'd0, want_median});
			end
			rx_hold = no_idle ? 0 : $urandom_range(0, 10);
			if (rx_hold != 0)
				m_axis_tready <= 1'b0;
		end else if (!m_axis_tready) begin
			if (rx_hold <= 1)
				m_axis_tready <= 1'b1;
			else
				rx_hold--;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[sliding_window_median] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_size_limits();
		test_random_traffic();
		wait_idle();
		repeat (10) @(posedge clk);
		if (median_queue.size() != 0)
			report_mismatch("results never arrived", '0, 40'(median_queue.size()));
		if (error_count == 0)
			$display("[sliding_window_median] OK");
		else
			$display("[sliding_window_median] ERROR");
		$finish;
	end

endmodule

>>> sim.f
design/smed_pkg.sv
design/smed_cell.sv
design/smed_median_out.sv
design/sliding_window_median.sv
verif/testbench.sv
